// ===== hdl/tibc_pkg.sv =====
// Shared types and codes for the terminal input byte classifier.
// No dependencies; imported by terminal_input_byte_classifier_core.
package tibc_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [2:0] t_class;
    typedef logic [2:0] t_store_op;

    // Byte classes reported with each result.
    localparam t_class CLS_CHAR  = 3'd0;
    localparam t_class CLS_INTER = 3'd1;
    localparam t_class CLS_CSI   = 3'd2;
    localparam t_class CLS_ST    = 3'd3;
    localparam t_class CLS_UTF8  = 3'd4;

    // Store actions for the downstream sequence buffer.
    localparam t_store_op OP_NONE    = 3'd0;
    localparam t_store_op OP_CLEAR   = 3'd1;
    localparam t_store_op OP_CLRPUSH = 3'd2;
    localparam t_store_op OP_PUSH    = 3'd3;
    localparam t_store_op OP_POP     = 3'd4;

    // Byte values the parser reacts to.
    localparam t_byte BYTE_BEL   = 8'h07;
    localparam t_byte BYTE_ESC   = 8'h1b;
    localparam t_byte BYTE_LBRKT = 8'h5b;
    localparam t_byte BYTE_RBRKT = 8'h5d;
    localparam t_byte BYTE_P     = 8'h50;
    localparam t_byte BYTE_BSLSH = 8'h5c;
    localparam t_byte BYTE_ST8   = 8'h9c;
    localparam t_byte FINAL_LO   = 8'h40;
    localparam t_byte FINAL_HI   = 8'h7e;

endpackage

// ===== hdl/terminal_input_byte_classifier_core.sv =====
// Terminal input byte classifier: ANSI escape and UTF-8 parser, one byte per cycle unless stalled.
// Depends on tibc_pkg for types, byte constants, class and store action codes.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_byte
//  out     | output    | o_out_valid / i_out_ready | o_byte_class, o_echo_byte, o_store_op
//
// Each accepted byte is classified in the cycle it is accepted and its result is
// captured in the output register, so it appears on the out channel in the next cycle.
// The parser state and the output register update together, which gives one
// transaction per cycle, limited only by the single output register.
// Reset (i_rst_n low, synchronous) returns the parser to idle and empties the
// output register. A stall on the out channel holds the result in place; the in
// channel stays ready as long as the held result is taken in the same cycle.
module terminal_input_byte_classifier_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  tibc_pkg::t_byte       i_in_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output tibc_pkg::t_class      o_byte_class,
    output tibc_pkg::t_byte       o_echo_byte,
    output tibc_pkg::t_store_op   o_store_op
);
    import tibc_pkg::*;

    // Parse mode codes. Codes five to seven never occur and behave as idle.
    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_ESC  = 3'd1;
    localparam logic [2:0] MODE_CSI  = 3'd2;
    localparam logic [2:0] MODE_ST   = 3'd3;
    localparam logic [2:0] MODE_UTF8 = 3'd4;

    // Parser state.
    logic [2:0] r_mode, n_mode;
    logic [2:0] r_utf8_expected, n_utf8_expected;
    logic [2:0] r_utf8_seen, n_utf8_seen;
    logic       r_last_esc, n_last_esc;

    // Output register.
    logic       r_out_valid;
    t_class     r_class, n_class;
    t_byte      r_echo;
    t_store_op  r_op, n_op;
    logic [2:0] w_seen_inc;
    logic       w_accept;

    // The output register can take a new result when it is empty or being drained.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_seen_inc = r_utf8_seen + 3'd1;

    always_comb begin
        n_mode          = r_mode;
        n_utf8_expected = r_utf8_expected;
        n_utf8_seen     = r_utf8_seen;
        n_class         = CLS_CHAR;
        n_op            = OP_NONE;
        case (r_mode)
            MODE_ESC: begin
                if (i_in_byte == BYTE_LBRKT) begin
                    n_op    = OP_CLEAR;
                    n_mode  = MODE_CSI;
                    n_class = CLS_INTER;
                end else if (i_in_byte == BYTE_ESC) begin
                    n_class = CLS_INTER;
                end else if (i_in_byte == BYTE_P || i_in_byte == BYTE_RBRKT) begin
                    // OSC and DCS strings run until a string terminator.
                    n_op    = OP_CLRPUSH;
                    n_mode  = MODE_ST;
                    n_class = CLS_INTER;
                end else begin
                    n_mode = MODE_IDLE;
                end
            end
            MODE_CSI: begin
                n_op = OP_PUSH;
                if (i_in_byte >= FINAL_LO && i_in_byte <= FINAL_HI) begin
                    n_mode  = MODE_IDLE;
                    n_class = CLS_CSI;
                end else begin
                    n_class = CLS_INTER;
                end
            end
            MODE_ST: begin
                if (i_in_byte == BYTE_BEL || i_in_byte == BYTE_ST8) begin
                    n_mode  = MODE_IDLE;
                    n_class = CLS_ST;
                end else if (i_in_byte == BYTE_BSLSH && r_last_esc) begin
                    // ESC backslash: drop the ESC already pushed.
                    n_mode  = MODE_IDLE;
                    n_op    = OP_POP;
                    n_class = CLS_ST;
                end else begin
                    n_op    = OP_PUSH;
                    n_class = CLS_INTER;
                end
            end
            MODE_UTF8: begin
                n_op        = OP_PUSH;
                n_utf8_seen = w_seen_inc;
                if (w_seen_inc == r_utf8_expected) begin
                    n_mode  = MODE_IDLE;
                    n_class = CLS_UTF8;
                end else begin
                    n_class = CLS_INTER;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
                if (i_in_byte[7:6] == 2'b11) begin
                    if (i_in_byte[5] == 1'b0) begin
                        n_utf8_expected = 3'd2;
                    end else if (i_in_byte[4] == 1'b0) begin
                        n_utf8_expected = 3'd3;
                    end else if (i_in_byte[3] == 1'b0) begin
                        n_utf8_expected = 3'd4;
                    end
                    if (i_in_byte[5:3] == 3'b111) begin
                        // Invalid lead byte: reported as a plain char, buffer cleared.
                        n_op = OP_CLEAR;
                    end else begin
                        n_op        = OP_CLRPUSH;
                        n_utf8_seen = 3'd1;
                        n_mode      = MODE_UTF8;
                        n_class     = CLS_INTER;
                    end
                end else if (i_in_byte == BYTE_ESC) begin
                    n_mode  = MODE_ESC;
                    n_class = CLS_INTER;
                end
            end
        endcase

        // Track whether the newest byte held downstream is ESC.
        n_last_esc = r_last_esc;
        if (n_op == OP_PUSH || n_op == OP_CLRPUSH) begin
            n_last_esc = (i_in_byte == BYTE_ESC);
        end else if (n_op == OP_CLEAR || n_op == OP_POP) begin
            n_last_esc = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= MODE_IDLE;
            r_utf8_expected <= 3'd0;
            r_utf8_seen     <= 3'd0;
            r_last_esc      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (w_accept) begin
                r_mode          <= n_mode;
                r_utf8_expected <= n_utf8_expected;
                r_utf8_seen     <= n_utf8_seen;
                r_last_esc      <= n_last_esc;
                r_out_valid     <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid     <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_class <= n_class;
            r_echo  <= i_in_byte;
            r_op    <= n_op;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_byte_class = r_class;
    assign o_echo_byte  = r_echo;
    assign o_store_op   = r_op;

    // Inside a UTF-8 character the count stays below the expected length.
    a_utf8_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_UTF8) |-> (r_utf8_seen < r_utf8_expected))
        else $error("UTF-8 byte count reached its length without leaving UTF-8 mode");

    // A pop only ever finishes a string on the backslash of ESC backslash.
    a_pop_is_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_op == OP_POP) |-> (r_class == CLS_ST && r_echo == BYTE_BSLSH))
        else $error("pop issued outside an ESC backslash terminator");

    // Completed CSI sequences and UTF-8 characters push their last byte.
    a_complete_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_class == CLS_CSI || r_class == CLS_UTF8)) |-> (r_op == OP_PUSH))
        else $error("completed sequence without a push");

    // An accepted ESC in idle always leads into escape mode.
    a_esc_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_mode == MODE_IDLE && i_in_byte == BYTE_ESC) |=> (r_mode == MODE_ESC))
        else $error("ESC in idle did not enter escape mode");

endmodule
